// ----- rtl/core/sfp_pkg.sv -----
// shared widths, reset values and result word type of the frame parser
package sfp_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] StartByteRst = 8'h02;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    byte_t payload_byte;
    byte_t byte_index;
    logic  frame_end;
    logic  sum_ok;
    byte_t packet_kind;
    byte_t link_status;
    byte_t payload_length;
  } res_t;

endpackage

// ----- rtl/core/sfp_rx_if.sv -----
// receive byte channel: valid, ready and one received byte
interface sfp_rx_if;
  import sfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfp_res_if.sv -----
// result channel: valid, ready and the payload or frame-end word
interface sfp_res_if;
  import sfp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t payload_byte;
  byte_t byte_index;
  logic  frame_end;
  logic  sum_ok;
  byte_t packet_kind;
  byte_t link_status;
  byte_t payload_length;

  modport source (
    output valid, output payload_byte, output byte_index, output frame_end,
    output sum_ok, output packet_kind, output link_status, output payload_length,
    input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_index, input frame_end,
    input sum_ok, input packet_kind, input link_status, input payload_length,
    output ready
  );
endinterface

// ----- rtl/core/sfp_in_stage.sv -----
// input register stage holding one received byte
module sfp_in_stage
  import sfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  byte_t byte_i,
  output logic  valid_o,
  input  logic  take_i,
  output byte_t byte_o
);

  logic  valid_q, valid_d;
  byte_t byte_q, byte_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (ready_o) begin
      valid_d = valid_i;
      byte_d  = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- rtl/core/sfp_parser.sv -----
// frame state machine, additive checksum and result register
module sfp_parser
  import sfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  byte_t start_byte_i,
  input  logic  valid_i,
  input  byte_t byte_i,
  output logic  take_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  typedef enum logic [2:0] {
    PhHunt,
    PhStatus,
    PhKind,
    PhLength,
    PhData,
    PhCheck,
    PhEnd
  } phase_e;

  phase_e phase_q, phase_d;
  byte_t  status_q, status_d;
  byte_t  kind_q, kind_d;
  byte_t  length_q, length_d;
  byte_t  taken_q, taken_d;
  byte_t  sum_q, sum_d;
  logic   res_valid_q, res_valid_d;
  res_t   res_q, res_d;
  logic   emit;
  res_t   emit_word;
  byte_t  taken_inc;

  assign take_o    = valid_i && (!res_valid_q || res_ready_i);
  assign taken_inc = taken_q + byte_t'(1);

  always_comb begin
    phase_d   = phase_q;
    status_d  = status_q;
    kind_d    = kind_q;
    length_d  = length_q;
    taken_d   = taken_q;
    sum_d     = sum_q;
    emit      = 1'b0;
    emit_word = '{
      payload_byte:   byte_i,
      byte_index:     taken_q,
      frame_end:      1'b0,
      sum_ok:         1'b0,
      packet_kind:    kind_q,
      link_status:    status_q,
      payload_length: length_q
    };
    unique case (phase_q)
      PhStatus: begin
        status_d = byte_i;
        sum_d    = sum_q + byte_i;
        phase_d  = PhKind;
      end
      PhKind: begin
        kind_d  = byte_i;
        sum_d   = sum_q + byte_i;
        phase_d = PhLength;
      end
      PhLength: begin
        length_d = byte_i;
        sum_d    = sum_q + byte_i;
        phase_d  = (byte_i == '0) ? PhCheck : PhData;
      end
      PhData: begin
        emit    = 1'b1;
        taken_d = taken_inc;
        sum_d   = sum_q + byte_i;
        if (taken_inc >= length_q) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        emit                 = 1'b1;
        emit_word.byte_index = '0;
        emit_word.frame_end  = 1'b1;
        emit_word.sum_ok     = (byte_i == sum_q);
        phase_d              = PhEnd;
      end
      PhEnd: begin
        phase_d = PhHunt;
      end
      default: begin
        if (byte_i == start_byte_i) begin
          phase_d = PhStatus;
          taken_d = '0;
          sum_d   = '0;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (take_o && emit) begin
      res_valid_d = 1'b1;
      res_d       = emit_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      status_q    <= '0;
      kind_q      <= '0;
      length_q    <= '0;
      taken_q     <= '0;
      sum_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        phase_q  <= phase_d;
        status_q <= status_d;
        kind_q   <= kind_d;
        length_q <= length_d;
        taken_q  <= taken_d;
        sum_q    <= sum_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/stx_frame_parser_with_sum_check.sv -----
// Start-byte framed packet receiver with an 8-bit additive checksum. One
// received byte is taken per cycle, sustained, as long as the result side
// keeps taking words. A byte is registered on entry, then parsed into the
// state machine and the result register: a payload or frame-end word passes
// the input register, then the result register, and can stall between them.
// Header and end bytes give no word. The rate is set by the joint update of
// the frame state, the running sum and the output register; input ready
// follows the result register's ready through the input stage.
module stx_frame_parser_with_sum_check
  import sfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  byte_t      cfg_wdata_i,
  sfp_rx_if.sink     rx_i,
  sfp_res_if.source  res_o
);

  byte_t start_byte_q;
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_take;
  res_t  res_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
    end else if (cfg_we_i) begin
      start_byte_q <= cfg_wdata_i;
    end
  end

  sfp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .ready_o (rx_i.ready),
    .byte_i  (rx_i.rx_byte),
    .valid_o (s1_valid),
    .take_i  (s1_take),
    .byte_o  (s1_byte)
  );

  sfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_byte_i (start_byte_q),
    .valid_i      (s1_valid),
    .byte_i       (s1_byte),
    .take_o       (s1_take),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res_word)
  );

  assign res_o.payload_byte   = res_word.payload_byte;
  assign res_o.byte_index     = res_word.byte_index;
  assign res_o.frame_end      = res_word.frame_end;
  assign res_o.sum_ok         = res_word.sum_ok;
  assign res_o.packet_kind    = res_word.packet_kind;
  assign res_o.link_status    = res_word.link_status;
  assign res_o.payload_length = res_word.payload_length;

endmodule
